// File: hw/rtl/ccft_pkg.sv
// ----------------------------------------------------------------------------
// ccft_pkg
// Types, codes and constants shared by the channel credit table modules.
// ----------------------------------------------------------------------------
package ccft_pkg;

    localparam int unsigned SLOTS   = 16;
    localparam int unsigned SLOT_W  = $clog2(SLOTS);
    localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
    localparam logic [63:0] MAX_U64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        REQ_RESERVE   = 4'd0,
        REQ_UNRESERVE = 4'd1,
        REQ_OPEN      = 4'd2,
        REQ_GRANT     = 4'd3,
        REQ_SEND      = 4'd4,
        REQ_PDATA     = 4'd5,
        REQ_PCLOSE    = 4'd6,
        REQ_PCREDIT   = 4'd7,
        REQ_CANCEL    = 4'd8,
        REQ_ABORT     = 4'd9,
        REQ_CLOSEALL  = 4'd10,
        REQ_QUERY     = 4'd11
    } t_req;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_STATE    = 3'd1;
    localparam logic [2:0] ST_QUOTA    = 3'd2;
    localparam logic [2:0] ST_PROTO    = 3'd3;
    localparam logic [2:0] ST_INTERNAL = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_RETRY    = 3'd6;
    localparam logic [2:0] ST_HANDLE   = 3'd7;

    localparam logic [1:0] EM_NONE   = 2'd0;
    localparam logic [1:0] EM_WINDOW = 2'd1;
    localparam logic [1:0] EM_CLOSE  = 2'd2;
    localparam logic [1:0] EM_DATA   = 2'd3;

    localparam logic [1:0] CC_CANCEL = 2'd0;
    localparam logic [1:0] CC_PEER   = 2'd1;
    localparam logic [1:0] CC_ABORT  = 2'd2;
    localparam logic [1:0] CC_ALL    = 2'd3;

    localparam logic [0:0] CFG_MAX_OPEN = 1'd0;
    localparam logic [0:0] CFG_READY    = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_READ,
        S_EXEC,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic read;
        logic exec;
        logic done;
    } t_cmd;

endpackage

// File: hw/rtl/ccft_ctrl.sv
// ----------------------------------------------------------------------------
// ccft_ctrl
// Sequencer: capture, identifier match, slot read, execute, result beat.
// ----------------------------------------------------------------------------
module ccft_ctrl
    import ccft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_READ;
            S_READ:   n_state = S_EXEC;
            S_EXEC:   n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_start;
        o_cmd.lookup  = (r_state == S_LOOKUP);
        o_cmd.read    = (r_state == S_READ);
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.done    = (r_state == S_DONE);
        o_busy        = (r_state != S_IDLE);
    end

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> r_state == S_LOOKUP)
        else $error("start not taken");
    a_exec_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_cmd.done)
        else $error("result beat missing");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.lookup, o_cmd.read, o_cmd.exec, o_cmd.done}))
        else $error("overlapping commands");

endmodule

// File: hw/rtl/ccft_dp.sv
// ----------------------------------------------------------------------------
// ccft_dp
// Slot table, counters and request evaluation.
// ----------------------------------------------------------------------------
module ccft_dp
    import ccft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic [3:0]  i_req_type,
    input  logic [3:0]  i_slot_index,
    input  logic [63:0] i_chan_ident,
    input  logic [15:0] i_module_tag,
    input  logic [31:0] i_byte_amount,
    input  logic        i_recv_limited,
    input  logic [63:0] i_recv_limit,
    input  logic        i_send_limited,
    input  logic [63:0] i_send_limit,
    input  logic [3:0]  i_option_bits,
    input  logic        i_link_accepts,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_result_slot,
    output logic [63:0] o_result_ident,
    output logic [1:0]  o_emit_kind,
    output logic [31:0] o_emit_amount,
    output logic        o_closed_notice,
    output logic [1:0]  o_close_cause,
    output logic [4:0]  o_closed_total
);

    // configuration
    logic [4:0] r_max_open;
    logic       r_ready;

    // slot table
    logic [SLOTS-1:0] r_open;
    logic [63:0]      r_ident   [SLOTS];
    logic [15:0]      r_module  [SLOTS];
    logic [1:0]       r_sinks   [SLOTS];
    logic             r_rlim    [SLOTS];
    logic             r_slim    [SLOTS];
    logic [63:0]      r_rleft   [SLOTS];
    logic [63:0]      r_sleft   [SLOTS];
    logic [63:0]      r_rcred   [SLOTS];
    logic [63:0]      r_scred   [SLOTS];
    logic [63:0]      r_highest;
    logic [CNT_W-1:0] r_open_total;
    logic [CNT_W-1:0] r_resv_total;

    // captured request
    logic [3:0]  r_req;
    logic [3:0]  r_sl;
    logic [63:0] r_id;
    logic [15:0] r_mod;
    logic [31:0] r_amt;
    logic        r_in_rlim;
    logic [63:0] r_in_rmax;
    logic        r_in_slim;
    logic [63:0] r_in_smax;
    logic [3:0]  r_opt;
    logic        r_acc;

    // lookup / read stage
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free_ok;
    logic [SLOT_W-1:0] r_free_slot;
    logic [SLOT_W-1:0] r_s;
    logic              r_s_open;
    logic [63:0]       r_s_ident;
    logic [15:0]       r_s_module;
    logic [1:0]        r_s_sinks;
    logic              r_s_rlim;
    logic              r_s_slim;
    logic [63:0]       r_s_rleft;
    logic [63:0]       r_s_sleft;
    logic [63:0]       r_s_rcred;
    logic [63:0]       r_s_scred;

    // result
    logic [2:0]  r_st;
    logic [3:0]  r_rslot;
    logic [63:0] r_rid;
    logic [1:0]  r_ek;
    logic [31:0] r_eamt;
    logic        r_notice;
    logic [1:0]  r_cause;
    logic [4:0]  r_ctotal;

    logic              n_hit, n_free_ok;
    logic [SLOT_W-1:0] n_hit_slot, n_free_slot;

    // identifier match and first free slot
    always_comb begin
        n_hit       = 1'b0;
        n_hit_slot  = '0;
        n_free_ok   = 1'b0;
        n_free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_open[i] && r_ident[i] == r_id) begin
                n_hit      = 1'b1;
                n_hit_slot = SLOT_W'(i);
            end
            if (!r_open[i]) begin
                n_free_ok   = 1'b1;
                n_free_slot = SLOT_W'(i);
            end
        end
    end

    // execute stage values
    logic              e_peer;
    logic              e_sl_ok;
    logic [64:0]       e_rsum, e_ssum;
    logic [63:0]       e_rcred_sub, e_rleft_sub;
    logic [CNT_W:0]    e_used;
    logic [2:0]        n_st;
    logic [3:0]        n_rslot;
    logic [63:0]       n_rid;
    logic [1:0]        n_ek;
    logic [31:0]       n_eamt;
    logic              n_notice;
    logic [1:0]        n_cause;
    logic [4:0]        n_ctotal;
    logic              w_drop, w_open, w_rcred, w_scred, w_sleft, w_rleft, w_all;
    logic              w_highest, w_resv_inc, w_resv_dec;
    logic [63:0]       w_rcred_val, w_scred_val, w_sleft_val, w_rleft_val;
    logic [CNT_W-1:0]  e_cnt;

    always_comb begin
        e_peer      = (r_req == REQ_PDATA) || (r_req == REQ_PCLOSE) || (r_req == REQ_PCREDIT);
        e_sl_ok     = r_s_open;
        e_rsum      = {1'b0, r_s_rcred} + {33'b0, r_amt};
        e_ssum      = {1'b0, r_s_scred} + {33'b0, r_amt};
        e_rcred_sub = r_s_rcred - {32'b0, r_amt};
        e_rleft_sub = r_s_rleft - {32'b0, r_amt};
        e_used      = {1'b0, r_open_total} + {1'b0, r_resv_total};
        e_cnt       = '0;
        for (int i = 0; i < SLOTS; i++) begin
            e_cnt = e_cnt + CNT_W'(r_open[i]);
        end
        n_st = ST_OK; n_rslot = '0; n_rid = '0; n_ek = EM_NONE; n_eamt = '0;
        n_notice = 1'b0; n_cause = CC_CANCEL; n_ctotal = '0;
        w_drop = 1'b0; w_open = 1'b0; w_rcred = 1'b0; w_scred = 1'b0;
        w_sleft = 1'b0; w_rleft = 1'b0; w_all = 1'b0; w_highest = 1'b0;
        w_resv_inc = 1'b0; w_resv_dec = 1'b0;
        w_rcred_val = '0; w_scred_val = '0; w_sleft_val = '0; w_rleft_val = '0;
        case (r_req)
            REQ_RESERVE: begin
                if (!r_ready) n_st = ST_STATE;
                else if (e_used >= {1'b0, r_max_open}) n_st = ST_QUOTA;
                else w_resv_inc = 1'b1;
            end
            REQ_UNRESERVE: w_resv_dec = (r_resv_total != '0);
            REQ_OPEN: begin
                if (r_id == '0 || r_mod == '0 || r_opt[1:0] == 2'b00) begin
                    w_resv_dec = r_opt[2] && (r_resv_total != '0);
                    n_st = ST_PROTO;
                end else if (r_opt[2] && r_resv_total == '0) begin
                    n_st = ST_INTERNAL;
                end else begin
                    w_resv_dec = r_opt[2];
                    if (!r_ready) n_st = ST_STATE;
                    else if (r_id <= r_highest) n_st = ST_PROTO;
                    else begin
                        w_highest = 1'b1;
                        if (r_open_total >= r_max_open || !r_free_ok) begin
                            n_st = ST_QUOTA;
                        end else begin
                            w_open  = 1'b1;
                            n_rslot = 4'(r_free_slot);
                            n_rid   = r_id;
                        end
                    end
                end
            end
            REQ_GRANT: begin
                if (!e_sl_ok || !r_ready) n_st = ST_STATE;
                else begin
                    n_rslot = r_sl; n_rid = r_s_ident;
                    if (e_rsum[64]) n_st = ST_OVERFLOW;
                    else begin
                        n_ek = EM_WINDOW; n_eamt = r_amt;
                        if (r_acc) begin
                            w_rcred = 1'b1; w_rcred_val = e_rsum[63:0];
                        end else n_st = ST_RETRY;
                    end
                end
            end
            REQ_SEND: begin
                if (!e_sl_ok || !r_ready || !r_s_sinks[1]) n_st = ST_STATE;
                else begin
                    n_rslot = r_sl; n_rid = r_s_ident;
                    if ({32'b0, r_amt} > r_s_scred ||
                        (r_s_slim && {32'b0, r_amt} > r_s_sleft)) n_st = ST_RETRY;
                    else begin
                        n_ek = EM_DATA; n_eamt = r_amt;
                        if (r_acc) begin
                            w_scred = 1'b1; w_scred_val = r_s_scred - {32'b0, r_amt};
                            w_sleft = r_s_slim; w_sleft_val = r_s_sleft - {32'b0, r_amt};
                        end else n_st = ST_RETRY;
                    end
                end
            end
            REQ_PDATA: begin
                if (!r_hit || !r_s_sinks[0] || {32'b0, r_amt} > r_s_rcred ||
                    (r_s_rlim && {32'b0, r_amt} > r_s_rleft)) n_st = ST_PROTO;
                else begin
                    n_rslot = 4'(r_s); n_rid = r_id;
                    w_rcred = 1'b1; w_rcred_val = e_rcred_sub;
                    w_rleft = r_s_rlim; w_rleft_val = e_rleft_sub;
                    if (!r_s_rlim || e_rleft_sub != '0) begin
                        if (r_ready) begin
                            n_ek = EM_WINDOW; n_eamt = r_amt;
                        end
                        if (r_ready && r_acc) w_rcred_val = r_s_rcred;
                        else begin
                            w_drop = 1'b1; n_notice = 1'b1; n_cause = CC_ABORT;
                            n_ctotal = 5'd1;
                        end
                    end
                end
            end
            REQ_PCLOSE, REQ_PCREDIT: begin
                if (!r_hit) begin
                    n_st = (r_id != '0 && r_id <= r_highest) ? ST_OK : ST_PROTO;
                end else begin
                    n_rslot = 4'(r_s); n_rid = r_id;
                    if (r_req == REQ_PCLOSE) begin
                        if (r_opt[3] && ((r_s_rlim && r_s_rleft != '0) ||
                                         (r_s_slim && r_s_sleft != '0))) n_st = ST_PROTO;
                        else begin
                            w_drop = 1'b1; n_notice = 1'b1; n_cause = CC_PEER;
                            n_ctotal = 5'd1;
                        end
                    end else begin
                        if (!r_s_sinks[1] || e_ssum[64] ||
                            (r_s_slim && e_ssum > {1'b0, r_s_sleft})) n_st = ST_PROTO;
                        else begin
                            w_scred = 1'b1; w_scred_val = e_ssum[63:0];
                        end
                    end
                end
            end
            REQ_CANCEL: begin
                if (!e_sl_ok) n_st = ST_STATE;
                else begin
                    n_rslot = r_sl; n_rid = r_s_ident; w_drop = 1'b1;
                    if (r_ready) n_ek = EM_CLOSE;
                    n_notice = 1'b1; n_ctotal = 5'd1;
                end
            end
            REQ_ABORT: begin
                if (e_sl_ok) begin
                    n_rslot = r_sl; n_rid = r_s_ident; w_drop = 1'b1;
                    n_notice = 1'b1; n_cause = CC_ABORT; n_ctotal = 5'd1;
                end
            end
            REQ_CLOSEALL: begin
                w_all    = 1'b1;
                n_ctotal = 5'(e_cnt);
                if (e_cnt != '0) begin
                    n_notice = 1'b1; n_cause = CC_ALL;
                end
            end
            REQ_QUERY: begin
                if (e_sl_ok && r_s_module == r_mod) begin
                    n_rslot = r_sl; n_rid = r_s_ident;
                end else n_st = ST_HANDLE;
            end
            default: n_st = ST_STATE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_open   <= 5'd16;
            r_ready      <= 1'b1;
            r_open       <= '0;
            r_highest    <= '0;
            r_open_total <= '0;
            r_resv_total <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_OPEN: r_max_open <= i_cfg_data;
                    CFG_READY:    r_ready    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                if (w_resv_inc) r_resv_total <= r_resv_total + 1'b1;
                if (w_resv_dec) r_resv_total <= r_resv_total - 1'b1;
                if (w_highest)  r_highest <= r_id;
                if (w_open) begin
                    r_open[r_free_slot] <= 1'b1;
                    r_open_total <= r_open_total + 1'b1;
                end
                if (w_drop) begin
                    r_open[r_s] <= 1'b0;
                    if (r_open_total != '0) r_open_total <= r_open_total - 1'b1;
                end
                if (w_all) begin
                    r_open       <= '0;
                    r_open_total <= (r_open_total > e_cnt) ? r_open_total - e_cnt : '0;
                end
            end
        end
    end

    // slot payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req_type; r_sl <= i_slot_index; r_id <= i_chan_ident;
            r_mod <= i_module_tag; r_amt <= i_byte_amount;
            r_in_rlim <= i_recv_limited; r_in_rmax <= i_recv_limit;
            r_in_slim <= i_send_limited; r_in_smax <= i_send_limit;
            r_opt <= i_option_bits; r_acc <= i_link_accepts;
        end
        if (i_cmd.lookup) begin
            r_hit <= n_hit; r_hit_slot <= n_hit_slot;
            r_free_ok <= n_free_ok; r_free_slot <= n_free_slot;
        end
        if (i_cmd.read) begin
            r_s        <= e_peer ? r_hit_slot : r_sl[SLOT_W-1:0];
            r_s_open   <= e_peer ? r_hit : r_open[r_sl[SLOT_W-1:0]];
            r_s_ident  <= r_ident[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_module <= r_module[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_sinks  <= r_sinks[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_rlim   <= r_rlim[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_slim   <= r_slim[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_rleft  <= r_rleft[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_sleft  <= r_sleft[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_rcred  <= r_rcred[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
            r_s_scred  <= r_scred[e_peer ? r_hit_slot : r_sl[SLOT_W-1:0]];
        end
        if (i_cmd.exec) begin
            r_st <= n_st; r_rslot <= n_rslot; r_rid <= n_rid; r_ek <= n_ek;
            r_eamt <= n_eamt; r_notice <= n_notice; r_cause <= n_cause;
            r_ctotal <= n_ctotal;
            if (w_open) begin
                r_ident[r_free_slot]  <= r_id;
                r_module[r_free_slot] <= r_mod;
                r_sinks[r_free_slot]  <= r_opt[1:0];
                r_rlim[r_free_slot]   <= r_in_rlim;
                r_slim[r_free_slot]   <= r_in_slim;
                r_rleft[r_free_slot]  <= r_in_rmax;
                r_sleft[r_free_slot]  <= r_in_smax;
                r_rcred[r_free_slot]  <= '0;
                r_scred[r_free_slot]  <= '0;
            end
            if (w_rcred) r_rcred[r_s] <= w_rcred_val;
            if (w_scred) r_scred[r_s] <= w_scred_val;
            if (w_sleft) r_sleft[r_s] <= w_sleft_val;
            if (w_rleft) r_rleft[r_s] <= w_rleft_val;
        end
    end

    assign o_done          = i_cmd.done;
    assign o_status        = r_st;
    assign o_result_slot   = r_rslot;
    assign o_result_ident  = r_rid;
    assign o_emit_kind     = r_ek;
    assign o_emit_amount   = r_eamt;
    assign o_closed_notice = r_notice;
    assign o_close_cause   = r_cause;
    assign o_closed_total  = r_ctotal;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_total <= CNT_W'(SLOTS))
        else $error("open count beyond table");
    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_open) |=> r_open_total == $past(r_open_total) + 1'b1)
        else $error("open count not advanced");
    a_notice_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_closed_notice == (o_closed_total != '0)))
        else $error("notice and total disagree");

endmodule

// File: hw/rtl/channel_credit_flow_table.sv
// ----------------------------------------------------------------------------
// channel_credit_flow_table
// Multiplexed channel table with per-channel byte-credit flow control.
//
// channel  handshake            payload
// request  i_start & !o_busy    i_req_type .. i_link_accepts
// result   o_done (one cycle)   o_status .. o_closed_total
// config   i_cfg_we             i_cfg_index, i_cfg_data
//
// a request is captured at its accepting edge; id match over the table, slot
// read and execute follow in that order, each in its own state, and the
// result beat is shown in the done state next; busy is high until it ends.
// the next request is accepted in the cycle after the result beat at the
// earliest, so a new request is not taken while one is still in flight.
// reset is synchronous; it empties the table, no clearing pass.
// results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module channel_credit_flow_table
    import ccft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic [3:0]  i_req_type,
    input  logic [3:0]  i_slot_index,
    input  logic [63:0] i_chan_ident,
    input  logic [15:0] i_module_tag,
    input  logic [31:0] i_byte_amount,
    input  logic        i_recv_limited,
    input  logic [63:0] i_recv_limit,
    input  logic        i_send_limited,
    input  logic [63:0] i_send_limit,
    input  logic [3:0]  i_option_bits,
    input  logic        i_link_accepts,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [3:0]  o_result_slot,
    output logic [63:0] o_result_ident,
    output logic [1:0]  o_emit_kind,
    output logic [31:0] o_emit_amount,
    output logic        o_closed_notice,
    output logic [1:0]  o_close_cause,
    output logic [4:0]  o_closed_total
);

    t_cmd w_cmd;

    ccft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd)
    );

    ccft_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_slot_index    (i_slot_index),
        .i_chan_ident    (i_chan_ident),
        .i_module_tag    (i_module_tag),
        .i_byte_amount   (i_byte_amount),
        .i_recv_limited  (i_recv_limited),
        .i_recv_limit    (i_recv_limit),
        .i_send_limited  (i_send_limited),
        .i_send_limit    (i_send_limit),
        .i_option_bits   (i_option_bits),
        .i_link_accepts  (i_link_accepts),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_result_slot   (o_result_slot),
        .o_result_ident  (o_result_ident),
        .o_emit_kind     (o_emit_kind),
        .o_emit_amount   (o_emit_amount),
        .o_closed_notice (o_closed_notice),
        .o_close_cause   (o_close_cause),
        .o_closed_total  (o_closed_total)
    );

endmodule

// File: sim/channel_credit_flow_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_credit_flow_table_tb
// Drives a directed request table and then biased random request traffic
// through several register settings. An in-bench channel table model
// predicts every result beat, which is checked field by field.
// ----------------------------------------------------------------------------
module channel_credit_flow_table_tb;
    import ccft_pkg::*;

    typedef struct {
        logic [3:0]  req;
        logic [3:0]  slot;
        logic [63:0] ident;
        logic [15:0] module_tag;
        logic [31:0] amount;
        logic        rlim;
        logic [63:0] rmax;
        logic        slim;
        logic [63:0] smax;
        logic [3:0]  opt;
        logic        accepts;
        logic        typed;
        logic [2:0]  t_status;
        logic [1:0]  t_emit;
        logic [1:0]  t_cause;
        logic [4:0]  t_total;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [63:0] ident;
        logic [1:0]  emit_kind;
        logic [31:0] emit_amount;
        logic        notice;
        logic [1:0]  cause;
        logic [4:0]  total;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;
    logic [3:0]  i_req_type;
    logic [3:0]  i_slot_index;
    logic [63:0] i_chan_ident;
    logic [15:0] i_module_tag;
    logic [31:0] i_byte_amount;
    logic        i_recv_limited;
    logic [63:0] i_recv_limit;
    logic        i_send_limited;
    logic [63:0] i_send_limit;
    logic [3:0]  i_option_bits;
    logic        i_link_accepts;
    logic        o_done;
    logic [2:0]  o_status;
    logic [3:0]  o_result_slot;
    logic [63:0] o_result_ident;
    logic [1:0]  o_emit_kind;
    logic [31:0] o_emit_amount;
    logic        o_closed_notice;
    logic [1:0]  o_close_cause;
    logic [4:0]  o_closed_total;

    channel_credit_flow_table u_dut (.*);

    // channel table model
    logic        ch_open [SLOTS];
    logic [63:0] ch_ident [SLOTS];
    logic [15:0] ch_module [SLOTS];
    logic [1:0]  ch_sinks [SLOTS];
    logic        ch_rlim [SLOTS];
    logic        ch_slim [SLOTS];
    logic [63:0] ch_rleft [SLOTS];
    logic [63:0] ch_sleft [SLOTS];
    logic [63:0] ch_rcred [SLOTS];
    logic [63:0] ch_scred [SLOTS];
    logic [63:0] top_ident;
    int          n_open;
    int          n_reserved;
    logic [4:0]  cfg_max_open;
    logic        cfg_ready;

    t_outcome    pending_beats[$];
    t_request    table_rows[$];
    int          errors;
    logic        no_idle;

    initial begin
        i_clk = 1'b0;
        forever begin
            #1 i_clk = 1'b1;
            #1 i_clk = 1'b0;
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int find_channel(logic [63:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (ch_open[i] && ch_ident[i] == id) return i;
        return -1;
    endfunction

    function automatic void drop_channel(int s);
        ch_open[s] = 1'b0;
        if (n_open != 0) n_open--;
    endfunction

    function automatic t_outcome apply_request(t_request r);
        t_outcome o;
        int s;
        logic resv;
        logic fail;
        o = '{default: '0};
        o.status = ST_OK;
        case (r.req)
            REQ_RESERVE: begin
                if (!cfg_ready) o.status = ST_STATE;
                else if (n_open + n_reserved >= cfg_max_open) o.status = ST_QUOTA;
                else n_reserved++;
            end
            REQ_UNRESERVE: begin
                if (n_reserved != 0) n_reserved--;
            end
            REQ_OPEN: begin
                resv = r.opt[2];
                s = -1;
                if (r.ident == 0 || r.module_tag == 0 || r.opt[1:0] == 0) begin
                    if (resv && n_reserved != 0) n_reserved--;
                    o.status = ST_PROTO;
                end else if (resv && n_reserved == 0) begin
                    o.status = ST_INTERNAL;
                end else begin
                    if (resv) n_reserved--;
                    if (!cfg_ready) o.status = ST_STATE;
                    else if (r.ident <= top_ident) o.status = ST_PROTO;
                    else begin
                        top_ident = r.ident;
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!ch_open[i]) s = i;
                        if (n_open >= cfg_max_open || s < 0) o.status = ST_QUOTA;
                        else begin
                            ch_open[s] = 1'b1;
                            ch_ident[s] = r.ident;
                            ch_module[s] = r.module_tag;
                            ch_sinks[s] = r.opt[1:0];
                            ch_rlim[s] = r.rlim;
                            ch_slim[s] = r.slim;
                            ch_rleft[s] = r.rmax;
                            ch_sleft[s] = r.smax;
                            ch_rcred[s] = '0;
                            ch_scred[s] = '0;
                            n_open++;
                            o.slot = s;
                            o.ident = r.ident;
                        end
                    end
                end
            end
            REQ_GRANT: begin
                if (!ch_open[r.slot] || !cfg_ready) o.status = ST_STATE;
                else begin
                    o.slot = r.slot;
                    o.ident = ch_ident[r.slot];
                    if (MAX_U64 - ch_rcred[r.slot] < {32'd0, r.amount})
                        o.status = ST_OVERFLOW;
                    else begin
                        o.emit_kind = EM_WINDOW;
                        o.emit_amount = r.amount;
                        if (r.accepts) ch_rcred[r.slot] += r.amount;
                        else o.status = ST_RETRY;
                    end
                end
            end
            REQ_SEND: begin
                if (!ch_open[r.slot] || !cfg_ready || !ch_sinks[r.slot][1])
                    o.status = ST_STATE;
                else begin
                    o.slot = r.slot;
                    o.ident = ch_ident[r.slot];
                    if (r.amount > ch_scred[r.slot] ||
                        (ch_slim[r.slot] && r.amount > ch_sleft[r.slot]))
                        o.status = ST_RETRY;
                    else begin
                        o.emit_kind = EM_DATA;
                        o.emit_amount = r.amount;
                        if (r.accepts) begin
                            ch_scred[r.slot] -= r.amount;
                            if (ch_slim[r.slot]) ch_sleft[r.slot] -= r.amount;
                        end else o.status = ST_RETRY;
                    end
                end
            end
            REQ_PDATA: begin
                s = find_channel(r.ident);
                if (s < 0) o.status = ST_PROTO;
                else if (!ch_sinks[s][0] || r.amount > ch_rcred[s] ||
                         (ch_rlim[s] && r.amount > ch_rleft[s]))
                    o.status = ST_PROTO;
                else begin
                    o.slot = s;
                    o.ident = r.ident;
                    ch_rcred[s] -= r.amount;
                    if (ch_rlim[s]) ch_rleft[s] -= r.amount;
                    if (!ch_rlim[s] || ch_rleft[s] != 0) begin
                        // automatic window refill; a refused one, or none while not ready, kills the channel
                        if (!cfg_ready) fail = 1'b1;
                        else begin
                            o.emit_kind = EM_WINDOW;
                            o.emit_amount = r.amount;
                            fail = !r.accepts;
                            if (!fail) ch_rcred[s] += r.amount;
                        end
                        if (fail) begin
                            drop_channel(s);
                            o.notice = 1'b1;
                            o.cause = CC_ABORT;
                            o.total = 5'd1;
                        end
                    end
                end
            end
            REQ_PCLOSE, REQ_PCREDIT: begin
                s = find_channel(r.ident);
                if (s < 0) begin
                    o.status = (r.ident != 0 && r.ident <= top_ident) ? ST_OK : ST_PROTO;
                end else begin
                    o.slot = s;
                    o.ident = r.ident;
                    if (r.req == REQ_PCLOSE) begin
                        if (r.opt[3] && ((ch_rlim[s] && ch_rleft[s] != 0) ||
                                         (ch_slim[s] && ch_sleft[s] != 0)))
                            o.status = ST_PROTO;
                        else begin
                            drop_channel(s);
                            o.notice = 1'b1;
                            o.cause = CC_PEER;
                            o.total = 5'd1;
                        end
                    end else if (!ch_sinks[s][1] ||
                                 MAX_U64 - ch_scred[s] < {32'd0, r.amount} ||
                                 (ch_slim[s] &&
                                  {1'b0, ch_scred[s]} + r.amount > {1'b0, ch_sleft[s]}))
                        o.status = ST_PROTO;
                    else ch_scred[s] += r.amount;
                end
            end
            REQ_CANCEL: begin
                if (!ch_open[r.slot]) o.status = ST_STATE;
                else begin
                    o.slot = r.slot;
                    o.ident = ch_ident[r.slot];
                    drop_channel(r.slot);
                    if (cfg_ready) o.emit_kind = EM_CLOSE;
                    o.notice = 1'b1;
                    o.cause = CC_CANCEL;
                    o.total = 5'd1;
                end
            end
            REQ_ABORT: begin
                if (ch_open[r.slot]) begin
                    o.slot = r.slot;
                    o.ident = ch_ident[r.slot];
                    drop_channel(r.slot);
                    o.notice = 1'b1;
                    o.cause = CC_ABORT;
                    o.total = 5'd1;
                end
            end
            REQ_CLOSEALL: begin
                for (int i = 0; i < SLOTS; i++)
                    if (ch_open[i]) begin
                        drop_channel(i);
                        o.total++;
                    end
                if (o.total != 0) begin
                    o.notice = 1'b1;
                    o.cause = CC_ALL;
                end
            end
            REQ_QUERY: begin
                if (ch_open[r.slot] && ch_module[r.slot] == r.module_tag) begin
                    o.slot = r.slot;
                    o.ident = ch_ident[r.slot];
                end else o.status = ST_HANDLE;
            end
            default: o.status = ST_STATE;
        endcase
        return o;
    endfunction

    task automatic add_row(logic [3:0] req, logic [3:0] slot, logic [63:0] id,
                           logic [15:0] mtag, logic [31:0] amt, logic [3:0] opt,
                           logic acc, logic rl, logic [63:0] rmax, logic sl,
                           logic [63:0] smax);
        t_request r;
        r = '{req: req, slot: slot, ident: id, module_tag: mtag, amount: amt,
              rlim: rl, rmax: rmax, slim: sl, smax: smax, opt: opt,
              accepts: acc, default: '0};
        table_rows.push_back(r);
    endtask

    // typed expectation for the last row: status, emit, cause, closed count
    task automatic row_expect(logic [2:0] st, logic [1:0] em, logic [1:0] cc,
                              logic [4:0] tot);
        table_rows[$].typed = 1'b1;
        table_rows[$].t_status = st;
        table_rows[$].t_emit = em;
        table_rows[$].t_cause = cc;
        table_rows[$].t_total = tot;
    endtask

    task automatic send_beat(t_request r);
        t_outcome o;
        i_start        <= 1'b1;
        i_req_type     <= r.req;
        i_slot_index   <= r.slot;
        i_chan_ident   <= r.ident;
        i_module_tag   <= r.module_tag;
        i_byte_amount  <= r.amount;
        i_recv_limited <= r.rlim;
        i_recv_limit   <= r.rmax;
        i_send_limited <= r.slim;
        i_send_limit   <= r.smax;
        i_option_bits  <= r.opt;
        i_link_accepts <= r.accepts;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        o = apply_request(r);
        if (r.typed) begin
            if (o.status != r.t_status || o.emit_kind != r.t_emit ||
                o.cause != r.t_cause || o.total != r.t_total) begin
                $error("table row outcome: expected st=%0d em=%0d cc=%0d n=%0d",
                       r.t_status, r.t_emit, r.t_cause, r.t_total);
                errors++;
            end
            o.status = r.t_status;
            o.emit_kind = r.t_emit;
            o.cause = r.t_cause;
            o.total = r.t_total;
        end
        pending_beats.push_back(o);
        if (!no_idle && $urandom_range(0, 99) < 32) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_write(logic [0:0] idx, logic [4:0] val);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAX_OPEN) cfg_max_open = val;
        else cfg_ready = val[0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_request random_request();
        t_request r;
        int k;
        int live[$];
        for (int i = 0; i < SLOTS; i++)
            if (ch_open[i]) live.push_back(i);
        r = '{default: '0};
        k = $urandom_range(0, 99);
        if (k < 8) r.req = REQ_RESERVE;
        else if (k < 12) r.req = REQ_UNRESERVE;
        else if (k < 30) r.req = REQ_OPEN;
        else if (k < 42) r.req = REQ_GRANT;
        else if (k < 54) r.req = REQ_SEND;
        else if (k < 68) r.req = REQ_PDATA;
        else if (k < 73) r.req = REQ_PCLOSE;
        else if (k < 83) r.req = REQ_PCREDIT;
        else if (k < 87) r.req = REQ_CANCEL;
        else if (k < 90) r.req = REQ_ABORT;
        else if (k < 92) r.req = REQ_CLOSEALL;
        else if (k < 98) r.req = REQ_QUERY;
        else r.req = $urandom_range(12, 15);

        if (live.size() != 0 && $urandom_range(0, 99) < 85)
            r.slot = live[$urandom_range(0, live.size() - 1)];
        else r.slot = $urandom_range(0, 15);

        k = $urandom_range(0, 99);
        if (r.req == REQ_OPEN) begin
            if (k < 90) r.ident = top_ident + $urandom_range(1, 4);
            else if (k < 95) r.ident = '0;
            else r.ident = rand64();
        end else if (live.size() != 0 && k < 80) begin
            r.ident = ch_ident[live[$urandom_range(0, live.size() - 1)]];
        end else if (k < 90) begin
            r.ident = rand64();
        end else begin
            r.ident = (top_ident > 3) ? top_ident - $urandom_range(0, 3) : 64'd0;
        end

        k = $urandom_range(0, 99);
        if (r.req == REQ_QUERY && ch_open[r.slot] && k < 80) r.module_tag = ch_module[r.slot];
        else if (k < 90) r.module_tag = $urandom_range(1, 65535);
        else r.module_tag = (k < 95) ? 16'd0 : 16'hFFFF;

        k = $urandom_range(0, 99);
        if (r.req == REQ_PDATA && k < 30 && find_channel(r.ident) >= 0 &&
            ch_rcred[find_channel(r.ident)] < 64'h1_0000_0000)
            r.amount = ch_rcred[find_channel(r.ident)];
        else if (k < 88) r.amount = $urandom_range(0, 64);
        else r.amount = $urandom;

        r.opt = $urandom_range(0, 15);
        if (r.req == REQ_OPEN && $urandom_range(0, 99) < 70) r.opt[1:0] = 2'b11;
        r.rlim = $urandom_range(0, 1);
        r.slim = $urandom_range(0, 1);
        r.rmax = ($urandom_range(0, 99) < 70) ? 64'($urandom_range(0, 500)) : rand64();
        r.smax = ($urandom_range(0, 99) < 70) ? 64'($urandom_range(0, 500)) : rand64();
        r.accepts = ($urandom_range(0, 9) != 0);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result beats cannot be stalled, so check on every done
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
            end else begin
                e = pending_beats.pop_front();
                check_field("status", e.status, o_status);
                check_field("result_slot", e.slot, o_result_slot);
                check_field("result_ident", e.ident, o_result_ident);
                check_field("emit_kind", e.emit_kind, o_emit_kind);
                check_field("emit_amount", e.emit_amount, o_emit_amount);
                check_field("closed_notice", e.notice, o_closed_notice);
                check_field("close_cause", e.cause, o_close_cause);
                check_field("closed_total", e.total, o_closed_total);
            end
        end
    end

    initial begin
        t_request r;
        int       wait_cycles;
        int       phase_max [6] = '{16, 0, 3, 16, 1, 16};
        int       phase_rdy [6] = '{1, 1, 1, 0, 1, 1};
        errors = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_req_type = '0;
        i_slot_index = '0;
        i_chan_ident = '0;
        i_module_tag = '0;
        i_byte_amount = '0;
        i_recv_limited = 1'b0;
        i_recv_limit = '0;
        i_send_limited = 1'b0;
        i_send_limit = '0;
        i_option_bits = '0;
        i_link_accepts = 1'b0;
        for (int i = 0; i < SLOTS; i++) ch_open[i] = 1'b0;
        top_ident = '0;
        n_open = 0;
        n_reserved = 0;
        cfg_max_open = 5'd16;
        cfg_ready = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(REQ_QUERY, 0, 0, 1, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_HANDLE, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_CANCEL, 3, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_STATE, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_ABORT, 15, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_OK, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_UNRESERVE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_OK, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_PDATA, 0, MAX_U64, 0, 0, 15, 1, 0, 0, 0, 0);
        row_expect(ST_PROTO, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_PCLOSE, 0, 5, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_PROTO, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_OPEN, 0, 0, 1, 0, 3, 1, 0, 0, 0, 0);
        row_expect(ST_PROTO, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_OPEN, 0, 1, 16'hFFFF, 0, 3, 1, 1, 100, 1, 50);
        row_expect(ST_OK, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_RESERVE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(REQ_OPEN, 0, 2, 7, 0, 7, 1, 0, MAX_U64, 0, MAX_U64);
        add_row(REQ_OPEN, 0, 1, 7, 0, 3, 1, 0, 0, 0, 0);
        row_expect(ST_PROTO, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_GRANT, 1, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0);
        add_row(REQ_GRANT, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        row_expect(ST_RETRY, EM_WINDOW, CC_CANCEL, 0);
        add_row(REQ_PCREDIT, 0, 1, 0, 40, 0, 1, 0, 0, 0, 0);
        add_row(REQ_SEND, 0, 0, 0, 40, 0, 1, 0, 0, 0, 0);
        add_row(REQ_PDATA, 0, 2, 0, 10, 0, 1, 0, 0, 0, 0);
        add_row(REQ_PDATA, 0, 2, 0, 10, 0, 0, 0, 0, 0, 0);
        row_expect(ST_OK, EM_WINDOW, CC_ABORT, 1);
        add_row(REQ_PCLOSE, 0, 2, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_OK, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_PCLOSE, 0, 1, 0, 0, 8, 1, 0, 0, 0, 0);
        row_expect(ST_PROTO, EM_NONE, CC_CANCEL, 0);
        add_row(4'd12, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_STATE, EM_NONE, CC_CANCEL, 0);
        add_row(4'd15, 15, MAX_U64, 16'hFFFF, 32'hFFFF_FFFF, 15, 1, 1, MAX_U64, 1, MAX_U64);
        row_expect(ST_STATE, EM_NONE, CC_CANCEL, 0);
        add_row(REQ_QUERY, 0, 0, 16'hFFFF, 0, 0, 1, 0, 0, 0, 0);
        add_row(REQ_OPEN, 0, 3, 9, 0, 1, 1, 0, 0, 0, 0);
        add_row(REQ_CANCEL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_OK, EM_CLOSE, CC_CANCEL, 1);
        add_row(REQ_CLOSEALL, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        row_expect(ST_OK, EM_NONE, CC_ALL, 1);
        foreach (table_rows[i]) send_beat(table_rows[i]);

        // random traffic over several register settings
        for (int p = 0; p < 6; p++) begin
            drain_and_write(CFG_MAX_OPEN, phase_max[p]);
            drain_and_write(CFG_READY, phase_rdy[p]);
            no_idle = (p == 0);
            for (int n = 0; n < 305; n++) begin
                if (p == 2 && n == 150) begin
                    // hold off until the block has nothing in flight
                    i_start <= 1'b0;
                    @(posedge i_clk);
                    while (pending_beats.size() != 0) @(posedge i_clk);
                end
                send_beat(random_request());
            end
        end
        no_idle = 1'b0;
        r = random_request();
        r.req = REQ_OPEN;
        r.ident = MAX_U64;
        r.module_tag = 16'hFFFF;
        r.opt = 4'b0011;
        send_beat(r);

        i_start <= 1'b0;
        wait_cycles = 0;
        @(posedge i_clk);
        while (pending_beats.size() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_beats.size() != 0) begin
            $error("%0d result beats never arrived", pending_beats.size());
            errors++;
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ccft_pkg.sv
hw/rtl/ccft_ctrl.sv
hw/rtl/ccft_dp.sv
hw/rtl/channel_credit_flow_table.sv
sim/channel_credit_flow_table_tb.sv
